// File: rtl/wad_pkg.sv
package wad_pkg;

	localparam int MAX_SAMPLES_DEF = 64;
	localparam int TAPS            = 4;
	localparam int TAP_W           = $clog2(TAPS);
	localparam int SAMPLE_W        = 16;
	localparam int COEFF_W         = 16;
	localparam int CFG_IDX_W       = 2;
	localparam int FRAC_W          = 14;
	localparam int PROD_W          = SAMPLE_W + COEFF_W;
	localparam int ACC_W           = PROD_W + TAP_W;
	localparam int COEF_OUT_W      = ACC_W - FRAC_W;

	// db2 low-pass analysis taps in Q1.14
	localparam logic signed [COEFF_W-1:0] COEFF_RST [TAPS] = '{
		-16'sd2120, 16'sd3672, 16'sd13705, 16'sd7913
	};

	typedef enum logic [1:0] {
		S_COLLECT,
		S_ISSUE,
		S_DRAIN
	} wad_state_t;

	typedef struct packed {
		logic             store;
		logic             close;
		logic             issue;
		logic [TAP_W-1:0] tap;
		logic             next_out;
	} wad_cmd_t;

	typedef struct packed {
		logic last_out;
		logic idle;
	} wad_sts_t;

endpackage

// File: rtl/wad_if.sv
interface wad_in_if;
	import wad_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       frame_end;

	modport source (output valid, sample, frame_end, input ready);
	modport sink (input valid, sample, frame_end, output ready);
endinterface

interface wad_out_if;
	import wad_pkg::*;
	logic                         valid;
	logic                         ready;
	logic signed [COEF_OUT_W-1:0] coefficient;
	logic                         final_res;
	logic                         overflow;

	modport source (output valid, coefficient, final_res, overflow, input ready);
	modport sink (input valid, coefficient, final_res, overflow, output ready);
endinterface

interface wad_cfg_if;
	import wad_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COEFF_W-1:0]   value;

	modport source (output valid, index, value, input ready);
	modport sink (input valid, index, value, output ready);
endinterface

// File: rtl/wad_ctrl.sv
module wad_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_end,
	output logic             in_ready,
	output wad_pkg::wad_cmd_t cmd,
	input  wad_pkg::wad_sts_t sts
);
	import wad_pkg::*;

	wad_state_t       state_q;
	wad_state_t       state_d;
	logic [TAP_W-1:0] tap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COLLECT;
			tap_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.issue) begin
				tap_q <= tap_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_COLLECT: begin
				if (in_valid && in_end) begin
					state_d = S_ISSUE;
				end
			end
			S_ISSUE: begin
				if (tap_q == TAP_W'(TAPS - 1)) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// wait until the word has left the output register
				if (sts.idle) begin
					state_d = sts.last_out ? S_COLLECT : S_ISSUE;
				end
			end
			default: state_d = S_COLLECT;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == S_COLLECT);
		cmd.store    = in_ready && in_valid;
		cmd.close    = in_ready && in_valid && in_end;
		cmd.issue    = (state_q == S_ISSUE);
		cmd.tap      = tap_q;
		cmd.next_out = (state_q == S_DRAIN) && sts.idle && !sts.last_out;
	end

endmodule

// File: rtl/wad_datapath.sv
module wad_datapath #(
	parameter int MAX_SAMPLES = wad_pkg::MAX_SAMPLES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  wad_pkg::wad_cmd_t                     cmd,
	output wad_pkg::wad_sts_t                     sts,
	input  logic signed [wad_pkg::SAMPLE_W-1:0]   sample,
	input  logic                                  cfg_we,
	input  logic [wad_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [wad_pkg::COEFF_W-1:0]           cfg_value,
	output logic                                  out_valid,
	input  logic                                  out_take,
	output logic signed [wad_pkg::COEF_OUT_W-1:0] coefficient,
	output logic                                  final_res,
	output logic                                  overflow
);
	import wad_pkg::*;

	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int ADDR_W = $clog2(MAX_SAMPLES);
	localparam int POS_W  = CNT_W + 3;
	localparam logic signed [POS_W-1:0] ONE_S = 1;
	localparam logic [CNT_W:0]          THREE = 3;

	logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];
	logic signed [COEFF_W-1:0]  coeff_q [TAPS];

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] n_q;
	logic             drop_q;
	logic             frame_drop_q;
	logic             full;
	logic [CNT_W:0]   total_w;
	logic [CNT_W-1:0] total;

	logic signed [POS_W-1:0] pos;
	logic signed [POS_W-1:0] len_s;
	logic signed [POS_W-1:0] mir;
	logic signed [POS_W-1:0] clamped;
	logic [ADDR_W-1:0]       rd_addr;

	logic                       v_s1;
	logic                       v_s2;
	logic signed [SAMPLE_W-1:0] rd_s1;
	logic [TAP_W-1:0]           tap_s1;
	logic                       last_s1;
	logic signed [PROD_W-1:0]   prod_s2;
	logic [TAP_W-1:0]           tap_s2;
	logic                       last_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    acc_sum;
	logic                       out_valid_q;
	logic signed [COEF_OUT_W-1:0] coef_q;
	logic                       final_q;
	logic                       ovf_q;

	assign full    = (count_q == CNT_W'(MAX_SAMPLES));
	assign total_w = ({1'b0, len_q} + THREE) >> 1;
	assign total   = total_w[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= COEFF_RST;
		end else if (cfg_we) begin
			coeff_q[cfg_index] <= cfg_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			len_q        <= '0;
			n_q          <= '0;
			drop_q       <= 1'b0;
			frame_drop_q <= 1'b0;
		end else begin
			if (cmd.store) begin
				if (!full) begin
					count_q <= count_q + 1'b1;
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (cmd.close) begin
				// a dropped closing word still ends the frame at full length
				len_q        <= full ? count_q : count_q + 1'b1;
				frame_drop_q <= drop_q | full;
				count_q      <= '0;
				drop_q       <= 1'b0;
				n_q          <= CNT_W'(1);
			end
			if (cmd.next_out) begin
				n_q <= n_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store && !full) begin
			mem[count_q[ADDR_W-1:0]] <= sample;
		end
	end

	// position 2n - tap - 1, mirrored back into the frame at both edges
	always_comb begin
		pos   = POS_W'(signed'({1'b0, n_q, 1'b0})) - POS_W'(signed'({1'b0, cmd.tap})) - ONE_S;
		len_s = POS_W'(signed'({1'b0, len_q}));
		if (pos < 0) begin
			mir = -pos - ONE_S;
		end else if (pos > len_s - ONE_S) begin
			mir = len_s + len_s - pos - ONE_S;
		end else begin
			mir = pos;
		end
		if (mir < 0) begin
			clamped = '0;
		end else if (mir > len_s - ONE_S) begin
			clamped = len_s - ONE_S;
		end else begin
			clamped = mir;
		end
		if (len_q <= CNT_W'(1)) begin
			rd_addr = '0;
		end else begin
			rd_addr = clamped[ADDR_W-1:0];
		end
	end

	always_comb begin
		if (tap_s2 == '0) begin
			acc_sum = ACC_W'(prod_s2);
		end else begin
			acc_sum = acc_q + ACC_W'(prod_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (v_s2 && tap_s2 == TAP_W'(TAPS - 1)) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_s1   <= mem[rd_addr];
		tap_s1  <= cmd.tap;
		last_s1 <= sts.last_out;
		prod_s2 <= PROD_W'(rd_s1) * PROD_W'(coeff_q[tap_s1]);
		tap_s2  <= tap_s1;
		last_s2 <= last_s1;
		if (v_s2) begin
			acc_q <= acc_sum;
			if (tap_s2 == TAP_W'(TAPS - 1)) begin
				coef_q  <= acc_sum[ACC_W-1:FRAC_W];
				final_q <= last_s2;
				ovf_q   <= frame_drop_q;
			end
		end
	end

	assign sts.last_out = (n_q == total);
	assign sts.idle     = !v_s1 && !v_s2 && !out_valid_q;
	assign out_valid    = out_valid_q;
	assign coefficient  = coef_q;
	assign final_res    = final_q;
	assign overflow     = ovf_q;

endmodule

// File: rtl/wavelet_analysis_decimator_top.sv
// One level of 4-tap wavelet analysis with mirrored frame edges and 2:1 decimation.
// din carries signed samples; the word with frame_end set closes the frame.
// A frame of L samples gives (L+3)/2 coefficient words on dout, the last one
// with final_res set; overflow is set on every word of a frame that had samples
// dropped once the store of MAX_SAMPLES entries was full.
// cfg writes one of the four Q1.14 taps (index 0..3) and is always ready; write
// it only between frames.
// Loading accepts one sample per cycle. After frame_end each coefficient is built
// from four tap reads through the single read port of the frame store, then the
// memory, multiply and accumulate stages, before the word is handed over on dout;
// the next coefficient starts only once that word has been taken. din is not
// ready from frame_end until the last word has been taken and the controller
// has gone back from its drain state to collecting.
// A stalled dout holds its word and the block waits; nothing is lost.
// Reset restores the default db2 taps and empties the frame; the store itself
// is not cleared.
module wavelet_analysis_decimator_top #(
	parameter int MAX_SAMPLES = wad_pkg::MAX_SAMPLES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	wad_in_if.sink    din,
	wad_out_if.source dout,
	wad_cfg_if.sink   cfg
);
	import wad_pkg::*;

	wad_cmd_t cmd;
	wad_sts_t sts;
	logic     in_ready;

	wad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_end   (din.frame_end),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	wad_datapath #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.sample      (din.sample),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_value   (cfg.value),
		.out_valid   (dout.valid),
		.out_take    (dout.valid && dout.ready),
		.coefficient (dout.coefficient),
		.final_res   (dout.final_res),
		.overflow    (dout.overflow)
	);

	assign din.ready = in_ready;
	assign cfg.ready = 1'b1;

	a_no_load_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready) |-> !dout.valid)
		else $error("sample word taken while a coefficient is pending");

	a_frame_end_stops_input: assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready && din.frame_end) |=> !din.ready)
		else $error("input still open after frame end");

	a_final_reopens_input: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.ready && dout.final_res) |-> ##2 din.ready)
		else $error("input not reopened after final coefficient");

endmodule

// File: dv/wad_coef_check.sv
module wad_coef_check #(
	parameter int MAX_SAMPLES = wad_pkg::MAX_SAMPLES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	wad_in_if    din,
	wad_out_if   dout,
	wad_cfg_if   cfg,
	output int   errors,
	output int   pending,
	output int   words_checked,
	output int   frames_closed,
	output int   overrun_frames
);
	import wad_pkg::*;

	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic signed [COEF_OUT_W-1:0] coefficient;
		logic                         final_res;
		logic                         overflow;
	} coef_word_t;

	logic signed [COEFF_W-1:0]  taps [TAPS];
	logic signed [SAMPLE_W-1:0] frame_buf [MAX_SAMPLES];
	int                         fill;
	logic                       dropped;
	coef_word_t                 coef_q [$];

	// Fold a filter position back into the frame: symmetric about both ends.
	function automatic logic signed [SAMPLE_W-1:0] mirrored(int p, int len);
		int i;
		if (len <= 1) begin
			return frame_buf[0];
		end
		if (p < 0) begin
			i = -p - 1;
		end else if (p > len - 1) begin
			i = 2 * len - p - 1;
		end else begin
			i = p;
		end
		if (i < 0) begin
			i = 0;
		end
		if (i > len - 1) begin
			i = len - 1;
		end
		return frame_buf[i];
	endfunction

	function automatic void close_frame();
		int         len;
		int         words;
		int         n;
		int         k;
		longint     acc;
		coef_word_t w;
		len   = fill;
		words = (len + TAPS - 1) / 2;
		for (n = 1; n <= words; n++) begin
			acc = 0;
			for (k = 0; k < TAPS; k++) begin
				acc += longint'(taps[k]) * longint'(mirrored(2 * n - k - 1, len));
			end
			w.coefficient = COEF_OUT_W'(acc >>> FRAC_W);
			w.final_res   = (n == words);
			w.overflow    = dropped;
			coef_q.push_back(w);
		end
		frames_closed++;
		if (dropped) begin
			overrun_frames++;
		end
		fill    = 0;
		dropped = 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		coef_word_t got;
		coef_word_t want;
		if (!arst_n) begin
			taps           = COEFF_RST;
			fill           = 0;
			dropped        = 1'b0;
			coef_q.delete();
			errors         = 0;
			words_checked  = 0;
			frames_closed  = 0;
			overrun_frames = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				taps[cfg.index] = cfg.value;
			end
			if (din.valid && din.ready) begin
				// full store: drop the word, remember it for the overflow flag
				if (fill < MAX_SAMPLES) begin
					frame_buf[fill] = din.sample;
					fill++;
				end else begin
					dropped = 1'b1;
				end
				if (din.frame_end) begin
					close_frame();
				end
			end
			if (dout.valid && dout.ready) begin
				got.coefficient = dout.coefficient;
				got.final_res   = dout.final_res;
				got.overflow    = dout.overflow;
				if (coef_q.size() == 0) begin
					errors++;
					if (errors <= REPORT_MAX) begin
						$display("unexpected word: coef %0d final %0b ovf %0b",
							got.coefficient, got.final_res, got.overflow);
					end
				end else begin
					want = coef_q.pop_front();
					words_checked++;
					if (got != want) begin
						errors++;
						if (errors <= REPORT_MAX) begin
							$display("word %0d: expected %0d f%0b o%0b, got %0d f%0b o%0b",
								words_checked,
								want.coefficient, want.final_res, want.overflow,
								got.coefficient, got.final_res, got.overflow);
						end
					end
				end
			end
		end
		pending = coef_q.size();
	end

endmodule

// File: dv/wavelet_analysis_decimator_top_tb.sv
module wavelet_analysis_decimator_top_tb;
	import wad_pkg::*;

	localparam int MAX_SAMPLES   = MAX_SAMPLES_DEF;
	localparam int LIMIT_CYCLES  = 200000;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_ITEMS   = 15;
	localparam int N_PHASES      = 4;
	localparam int SEND_IDLE_PCT [N_PHASES]  = '{0, 73, 0, 35};
	localparam int RECV_STALL_PCT [N_PHASES] = '{0, 0, 73, 35};

	localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

	typedef logic signed [COEFF_W-1:0] tap_set_t [TAPS];

	logic clk;
	logic arst_n;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   cycle_count    = 0;
	int   samples_sent   = 0;
	int   errors;
	int   pending;
	int   words_checked;
	int   frames_closed;
	int   overrun_frames;

	wad_in_if  din_ch ();
	wad_out_if dout_ch ();
	wad_cfg_if cfg_ch ();

	wavelet_analysis_decimator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_ch),
		.dout   (dout_ch),
		.cfg    (cfg_ch)
	);

	wad_coef_check #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.din            (din_ch),
		.dout           (dout_ch),
		.cfg            (cfg_ch),
		.errors         (errors),
		.pending        (pending),
		.words_checked  (words_checked),
		.frames_closed  (frames_closed),
		.overrun_frames (overrun_frames)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		dout_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		cycle_count   <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_count, pending);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] any_sample();
		case ($urandom_range(7))
			0: return S_MIN;
			1: return S_MAX;
			2: return SAMPLE_W'(int'($urandom_range(32)) - 16);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			din_ch.valid <= 1'b0;
			@(posedge clk);
		end
		din_ch.valid     <= 1'b1;
		din_ch.sample    <= s;
		din_ch.frame_end <= last;
		@(posedge clk);
		while (!din_ch.ready) begin
			@(posedge clk);
		end
		samples_sent++;
	endtask

	task automatic send_frame(input int len);
		int i;
		for (i = 0; i < len; i++) begin
			send_word(any_sample(), i == len - 1);
		end
	endtask

	// Hold the sender until every predicted word is out and the block is idle.
	task automatic drain_results();
		din_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_taps(input tap_set_t t);
		int i;
		for (i = 0; i < TAPS; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= CFG_IDX_W'(i);
			cfg_ch.value <= t[i];
			@(posedge clk);
			while (!cfg_ch.ready) begin
				@(posedge clk);
			end
		end
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		tap_set_t tap_set;
		int       ph;
		int       i;
		int       sent;
		int       len;

		arst_n           = 1'b0;
		din_ch.valid     = 1'b0;
		din_ch.sample    = '0;
		din_ch.frame_end = 1'b0;
		dout_ch.ready    = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = '0;
		cfg_ch.value     = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default taps: one-sample frames, then the shortest longer ones
		send_word(S_MIN, 1'b1);
		send_word(S_MAX, 1'b1);
		send_word(S_MAX, 1'b0);
		send_word(S_MIN, 1'b1);
		send_word(16'sd0, 1'b0);
		send_word(-16'sd1, 1'b0);
		send_word(16'sd1, 1'b1);
		drain_results();

		tap_set = '{S_MAX, S_MAX, S_MAX, S_MAX};
		write_taps(tap_set);
		for (i = 0; i < 4; i++) begin
			send_word(S_MAX, i == 3);
		end
		for (i = 0; i < 5; i++) begin
			send_word(i[0] ? S_MAX : S_MIN, i == 4);
		end
		drain_results();

		tap_set = '{S_MIN, S_MIN, S_MIN, S_MIN};
		write_taps(tap_set);
		for (i = 0; i < 3; i++) begin
			send_word(S_MIN, i == 2);
		end
		send_word(S_MAX, 1'b0);
		send_word(S_MAX, 1'b1);
		drain_results();

		tap_set = '{S_MAX, S_MIN, 16'sd0, -16'sd1};
		write_taps(tap_set);
		send_word(16'sh5555, 1'b0);
		send_word(16'shAAAA, 1'b0);
		send_word(16'sh00FF, 1'b1);

		for (ph = 0; ph < N_PHASES; ph++) begin
			drain_results();
			send_idle_pct  = SEND_IDLE_PCT[ph];
			recv_stall_pct = RECV_STALL_PCT[ph];
			if (ph == 1) begin
				tap_set = COEFF_RST;
			end else begin
				for (i = 0; i < TAPS; i++) begin
					tap_set[i] = COEFF_W'($urandom);
				end
			end
			write_taps(tap_set);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				len = ($urandom_range(9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 24);
				send_frame(len);
				sent += len;
				if ($urandom_range(7) == 0) begin
					drain_results();
				end
			end
			// close each phase with one long frame; two of them overrun the store
			case (ph)
				0, 3: send_frame(MAX_SAMPLES + $urandom_range(1, 4));
				1: send_frame(MAX_SAMPLES);
				default: send_frame($urandom_range(33, MAX_SAMPLES - 1));
			endcase
		end
		drain_results();
		repeat (20) @(posedge clk);

		$display("%0d samples in %0d frames (%0d overrun), %0d coefficient words compared",
			samples_sent, frames_closed, overrun_frames, words_checked);
		$display("paced free-running, with sender gaps, receiver stalls and both; 8 tap sets");
		if (pending != 0) begin
			$display("%0d predicted coefficient words never arrived", pending);
		end
		if (errors == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
